// ----- rtl/core/tmoc_pkg.sv -----
package tmoc_pkg;

  // Default tile store geometry.
  localparam int TMOC_MAP_COLS = 32;
  localparam int TMOC_MAP_ROWS = 32;

  // Clamp limits for the overlay side and the opacity.
  localparam logic [7:0] SIZE_MIN = 8'd32;
  localparam logic [7:0] SIZE_MAX = 8'd192;
  localparam logic [8:0] OPA_MIN  = 9'd26;
  localparam logic [8:0] OPA_MAX  = 9'd256;
  localparam logic [8:0] OPA_FULL = 9'd256;

  // Fixed colors.
  localparam logic [31:0] DARK_GREY    = 32'hFF10_1010;
  localparam logic [31:0] PARTY_WHITE  = 32'hFFFF_FFFF;
  localparam logic [31:0] ARROW_YELLOW = 32'hFFFF_FF00;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

  // Configuration register indexes.
  localparam logic [2:0] CFG_MODE   = 3'd0;
  localparam logic [2:0] CFG_SIZE   = 3'd1;
  localparam logic [2:0] CFG_OPA    = 3'd2;
  localparam logic [2:0] CFG_PCOL   = 3'd3;
  localparam logic [2:0] CFG_PROW   = 3'd4;
  localparam logic [2:0] CFG_FACING = 3'd5;
  localparam logic [2:0] CFG_FWIDTH = 3'd6;

  // Overlay modes; any mode above "all" shows visited cells only.
  localparam logic [1:0] MODE_OFF = 2'd0;
  localparam logic [1:0] MODE_ALL = 2'd1;

  // Request operations.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  typedef enum logic [1:0] {
    FACE_N = 2'd0,
    FACE_E = 2'd1,
    FACE_S = 2'd2,
    FACE_W = 2'd3
  } facing_t;

  typedef enum logic [3:0] {
    KIND_WALL      = 4'd0,
    KIND_FLOOR     = 4'd1,
    KIND_DOOR      = 4'd2,
    KIND_LOCKED    = 4'd3,
    KIND_STAIRS_UP = 4'd4,
    KIND_STAIRS_DN = 4'd5,
    KIND_SHOP      = 4'd6,
    KIND_TELEPORT  = 4'd7,
    KIND_GENERATOR = 4'd8,
    KIND_TERMINAL  = 4'd9
  } cell_kind_t;

  // Clamped and derived configuration seen by the pipeline.
  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  size;
    logic [6:0]  half;
    logic [5:0]  quarter;
    logic [8:0]  opa;
    logic [4:0]  pcol;
    logic [4:0]  prow;
    logic [1:0]  facing;
    logic [12:0] fwidth;
  } tmoc_cfg_t;

  // Request fields carried along the pipeline.
  typedef struct packed {
    logic        op;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [3:0]  kind;
    logic        seen;
    logic [31:0] bg;
    logic        bypass;
    logic        arrow;
  } tmoc_carry_t;

  // Geometry front end to cell lookup.
  typedef struct packed {
    tmoc_carry_t        carry;
    logic [6:0]         q0x;
    logic [6:0]         q0y;
    logic signed [15:0] remx;
    logic signed [15:0] remy;
  } tmoc_geo_t;

  // Cell lookup to blender.
  typedef struct packed {
    logic        bypass;
    logic        arrow;
    logic [31:0] bg;
    logic        in_map;
    logic        party;
    logic [3:0]  kind;
    logic        seen;
  } tmoc_cell_t;

  // Palette color of a cell kind; unpainted codes are dark grey.
  function automatic logic [31:0] palette_color(input logic [3:0] kind);
    logic [31:0] c;
    case (cell_kind_t'(kind))
      KIND_WALL:      c = 32'hFF40_4040;
      KIND_FLOOR:     c = 32'hFF80_8080;
      KIND_DOOR:      c = 32'hFF8B_4513;
      KIND_LOCKED:    c = 32'hFFFF_4500;
      KIND_STAIRS_UP: c = 32'hFF00_FF00;
      KIND_STAIRS_DN: c = 32'hFF00_CC00;
      KIND_SHOP:      c = 32'hFFFF_D700;
      KIND_TELEPORT:  c = 32'hFF8A_2BE2;
      KIND_GENERATOR: c = 32'hFFFF_0000;
      KIND_TERMINAL:  c = 32'hFF00_BFFF;
      default:        c = DARK_GREY;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/core/tmoc_in_if.sv -----
interface tmoc_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [11:0] pos_x;
  logic [11:0] pos_y;
  logic [3:0]  cell_kind;
  logic        cell_seen;
  logic [31:0] background;

  modport source (output valid, operation, pos_x, pos_y, cell_kind, cell_seen, background,
                  input ready);
  modport sink (input valid, operation, pos_x, pos_y, cell_kind, cell_seen, background,
                output ready);
endinterface

// ----- rtl/core/tmoc_out_if.sv -----
interface tmoc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_out;

  modport source (output valid, pixel_out, input ready);
  modport sink (input valid, pixel_out, output ready);
endinterface

// ----- rtl/core/tmoc_geom.sv -----
module tmoc_geom (
  input  logic                clk,
  input  logic                rst_n,
  input  tmoc_pkg::tmoc_cfg_t cfg,
  input  logic                up_valid,
  output logic                up_ready,
  input  logic                op,
  input  logic [11:0]         pos_x,
  input  logic [11:0]         pos_y,
  input  logic [3:0]          kind,
  input  logic                seen,
  input  logic [31:0]         bg,
  output logic                dn_valid,
  input  logic                dn_ready,
  output tmoc_pkg::tmoc_geo_t dn_data
);
  import tmoc_pkg::*;

  function automatic logic is_step(input logic [8:0] d);
    return (d == 9'd1) || (d == 9'd2) || (d == 9'd3);
  endfunction

  logic               en1, en2, en3;
  logic signed [14:0] left, px_full;
  logic signed [12:0] py_full;
  logic               in_box, arrow;
  logic [8:0]         dx, dy;

  logic        s1_v_r, s2_v_r, s3_v_r;
  tmoc_carry_t s1_c_r, s2_c_r, s3_c_r;
  logic [7:0]  s1_px_r, s1_py_r;
  logic [14:0] s2_prodx_r, s2_prody_r;
  logic [6:0]  s2_q0x_r, s2_q0y_r, s3_q0x_r, s3_q0y_r;
  logic [14:0] qsx, qsy;
  logic signed [15:0] s3_remx_r, s3_remy_r;

  // Stall propagates back only through full stages.
  assign en3      = !s3_v_r || dn_ready;
  assign en2      = !s2_v_r || en3;
  assign en1      = !s1_v_r || en2;
  assign up_ready = en1;

  // Overlay placement and the overlay box test.
  always_comb begin
    left    = $signed({2'b0, cfg.fwidth}) - $signed({7'b0, cfg.size}) - 15'sd4;
    px_full = $signed({3'b0, pos_x}) - left;
    py_full = $signed({1'b0, pos_y}) - 13'sd4;
    in_box  = (cfg.mode != MODE_OFF) && ({1'b0, pos_x} < cfg.fwidth) &&
              !px_full[14] && (px_full < $signed({7'b0, cfg.size})) &&
              !py_full[12] && (py_full < $signed({5'b0, cfg.size}));
  end

  // Arrow pixels: one to three steps from the overlay center along the facing.
  always_comb begin
    dx = {1'b0, px_full[7:0]} - {2'b0, cfg.half};
    dy = {1'b0, py_full[7:0]} - {2'b0, cfg.half};
    case (facing_t'(cfg.facing))
      FACE_N:  arrow = (dx == 9'd0) && is_step(9'd0 - dy);
      FACE_E:  arrow = (dy == 9'd0) && is_step(dx);
      FACE_S:  arrow = (dx == 9'd0) && is_step(dy);
      FACE_W:  arrow = (dy == 9'd0) && is_step(9'd0 - dx);
      default: arrow = 1'b0;
    endcase
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (en1) s1_v_r <= up_valid;
      if (en2) s2_v_r <= s1_v_r;
      if (en3) s3_v_r <= s2_v_r;
    end
  end

  // Stage one: request capture with overlay-relative position.
  always_ff @(posedge clk) begin
    if (en1) begin
      s1_c_r  <= '{op: op, pos_x: pos_x, pos_y: pos_y, kind: kind, seen: seen, bg: bg,
                   bypass: !in_box, arrow: arrow};
      s1_px_r <= px_full[7:0];
      s1_py_r <= py_full[7:0];
    end
  end

  // Stage two: scaled position px*2R and the estimate px/2 of the quotient.
  always_ff @(posedge clk) begin
    if (en2) begin
      s2_c_r     <= s1_c_r;
      s2_prodx_r <= 15'(s1_px_r) * 15'({cfg.quarter, 1'b0});
      s2_prody_r <= 15'(s1_py_r) * 15'({cfg.quarter, 1'b0});
      s2_q0x_r   <= s1_px_r[7:1];
      s2_q0y_r   <= s1_py_r[7:1];
    end
  end

  // Stage three: remainder of the estimate, corrected downstream.
  assign qsx = 15'(s2_q0x_r) * 15'(cfg.size);
  assign qsy = 15'(s2_q0y_r) * 15'(cfg.size);

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_c_r    <= s2_c_r;
      s3_q0x_r  <= s2_q0x_r;
      s3_q0y_r  <= s2_q0y_r;
      s3_remx_r <= $signed({1'b0, s2_prodx_r}) - $signed({1'b0, qsx});
      s3_remy_r <= $signed({1'b0, s2_prody_r}) - $signed({1'b0, qsy});
    end
  end

  assign dn_valid = s3_v_r;
  assign dn_data  = '{carry: s3_c_r, q0x: s3_q0x_r, q0y: s3_q0y_r,
                      remx: s3_remx_r, remy: s3_remy_r};

endmodule

// ----- rtl/core/tmoc_cell.sv -----
module tmoc_cell #(
  parameter int MAP_COLS = tmoc_pkg::TMOC_MAP_COLS,
  parameter int MAP_ROWS = tmoc_pkg::TMOC_MAP_ROWS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tmoc_pkg::tmoc_cfg_t  cfg,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  tmoc_pkg::tmoc_geo_t  up_data,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output tmoc_pkg::tmoc_cell_t dn_data
);
  import tmoc_pkg::*;

  localparam int DEPTH = MAP_COLS * MAP_ROWS;
  localparam int AW    = $clog2(DEPTH);

  // Quotient from the estimate: the true value is zero to two below it.
  function automatic logic [6:0] fix_q(input logic [6:0] q0, input logic signed [15:0] rem,
                                       input logic [7:0] s);
    logic signed [15:0] r1;
    logic [6:0]         q;
    r1 = rem + $signed({8'b0, s});
    if (!rem[15])     q = q0;
    else if (!r1[15]) q = q0 - 7'd1;
    else              q = q0 - 7'd2;
    return q;
  endfunction

  logic               en4, en5;
  logic [6:0]         qx, qy;
  logic signed [9:0]  mx, my;
  logic               in_map, party, wr_ok;
  logic [AW-1:0]      rd_addr, wr_addr;

  logic          s4_v_r, s5_v_r;
  tmoc_carry_t   s4_c_r;
  logic          s4_wr_ok_r, s4_in_map_r, s4_party_r;
  logic [AW-1:0] s4_addr_r;
  logic          s5_bypass_r, s5_arrow_r, s5_in_map_r, s5_party_r;
  logic [31:0]   s5_bg_r;
  logic [4:0]    rd_r;
  logic [4:0]    mem [DEPTH];

  assign en5      = !s5_v_r || dn_ready;
  assign en4      = !s4_v_r || en5;
  assign up_ready = en4;

  // Map cell around the party and its store address.
  always_comb begin
    qx      = fix_q(up_data.q0x, up_data.remx, cfg.size);
    qy      = fix_q(up_data.q0y, up_data.remy, cfg.size);
    mx      = $signed({5'b0, cfg.pcol}) - $signed({4'b0, cfg.quarter}) + $signed({3'b0, qx});
    my      = $signed({5'b0, cfg.prow}) - $signed({4'b0, cfg.quarter}) + $signed({3'b0, qy});
    in_map  = !mx[9] && (mx < $signed(10'(MAP_COLS))) &&
              !my[9] && (my < $signed(10'(MAP_ROWS)));
    party   = (mx == $signed({5'b0, cfg.pcol})) && (my == $signed({5'b0, cfg.prow}));
    rd_addr = AW'(32'(my[7:0]) * MAP_COLS + 32'(mx[7:0]));
    wr_ok   = (32'(up_data.carry.pos_x) < MAP_COLS) && (32'(up_data.carry.pos_y) < MAP_ROWS);
    wr_addr = AW'(32'(up_data.carry.pos_y) * MAP_COLS + 32'(up_data.carry.pos_x));
  end

  // Valid bits; cell writes end at the store.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else begin
      if (en4) s4_v_r <= up_valid;
      if (en5) s5_v_r <= s4_v_r && (s4_c_r.op == OP_PIXEL);
    end
  end

  // Stage four: address selection.
  always_ff @(posedge clk) begin
    if (en4) begin
      s4_c_r      <= up_data.carry;
      s4_wr_ok_r  <= wr_ok;
      s4_in_map_r <= in_map;
      s4_party_r  <= party;
      s4_addr_r   <= (up_data.carry.op == OP_PIXEL) ? rd_addr : wr_addr;
    end
  end

  // Stage five: tile store, written and read in request order.
  always_ff @(posedge clk) begin
    if (en5) begin
      if (s4_v_r && (s4_c_r.op == OP_WRITE) && s4_wr_ok_r) begin
        mem[s4_addr_r] <= {s4_c_r.kind, s4_c_r.seen};
      end
      rd_r <= mem[s4_addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      s5_bypass_r <= s4_c_r.bypass;
      s5_arrow_r  <= s4_c_r.arrow;
      s5_bg_r     <= s4_c_r.bg;
      s5_in_map_r <= s4_in_map_r;
      s5_party_r  <= s4_party_r;
    end
  end

  assign dn_valid = s5_v_r;
  assign dn_data  = '{bypass: s5_bypass_r, arrow: s5_arrow_r, bg: s5_bg_r,
                      in_map: s5_in_map_r, party: s5_party_r,
                      kind: rd_r[4:1], seen: rd_r[0]};

endmodule

// ----- rtl/core/tmoc_blend.sv -----
module tmoc_blend (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tmoc_pkg::tmoc_cfg_t  cfg,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  tmoc_pkg::tmoc_cell_t up_data,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output logic [31:0]          dn_pixel
);
  import tmoc_pkg::*;

  logic        en6, en7;
  logic        show;
  logic [31:0] fg;
  logic [8:0]  inv_opa;
  logic [31:0] pix;

  logic        s6_v_r, s7_v_r;
  logic        s6_bypass_r, s6_arrow_r;
  logic [31:0] s6_bg_r;
  logic [16:0] s6_fp_r [3];
  logic [16:0] s6_bp_r [3];
  logic [31:0] s7_pix_r;

  assign en7      = !s7_v_r || dn_ready;
  assign en6      = !s6_v_r || en7;
  assign up_ready = en6;

  // Map color of the cell.
  always_comb begin
    show = (cfg.mode == MODE_ALL) || up_data.seen;
    if (up_data.in_map && up_data.party)     fg = PARTY_WHITE;
    else if (up_data.in_map && show)         fg = palette_color(up_data.kind);
    else                                     fg = DARK_GREY;
    inv_opa = OPA_FULL - cfg.opa;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
      s7_v_r <= 1'b0;
    end else begin
      if (en6) s6_v_r <= up_valid;
      if (en7) s7_v_r <= s6_v_r;
    end
  end

  // Stage six: weighted channels.
  always_ff @(posedge clk) begin
    if (en6) begin
      s6_bypass_r <= up_data.bypass;
      s6_arrow_r  <= up_data.arrow;
      s6_bg_r     <= up_data.bg;
      for (int c = 0; c < 3; c++) begin
        s6_fp_r[c] <= 17'(fg[8*c +: 8]) * 17'(cfg.opa);
        s6_bp_r[c] <= 17'(up_data.bg[8*c +: 8]) * 17'(inv_opa);
      end
    end
  end

  // Stage seven: sums truncated to eight bits, then the result register.
  always_comb begin
    logic [17:0] sum;
    pix = {ALPHA_OPAQUE, 24'b0};
    for (int c = 0; c < 3; c++) begin
      sum = 18'(s6_fp_r[c]) + 18'(s6_bp_r[c]);
      pix[8*c +: 8] = sum[15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (en7) begin
      if (s6_bypass_r)     s7_pix_r <= s6_bg_r;
      else if (s6_arrow_r) s7_pix_r <= ARROW_YELLOW;
      else                 s7_pix_r <= pix;
    end
  end

  assign dn_valid = s7_v_r;
  assign dn_pixel = s7_pix_r;

endmodule

// ----- rtl/core/tile_map_overlay_compositor.sv -----
// Tile map overlay compositor.
// Requests arrive on in_ch. A cell write (operation 0) stores a cell kind and a
// visited mark in the tile store and returns nothing. A pixel request
// (operation 1) returns one pixel on out_ch: the background, or inside the
// square overlay at the top-right of the frame, the background blended with
// the map color of the cell under it, or the yellow facing arrow.
// Settings are written through cfg_we, cfg_idx and cfg_wdata while no request
// is in flight; size and opacity are clamped where used.
// The pipeline has seven register stages, in the geometry, cell lookup and blend
// sections. One request is taken every clock while in_ch.ready is high; the
// tile store has one port, used by each request as it passes stage five,
// which keeps writes and reads in request order.
// A stalled out_ch holds its result; upstream stages keep filling until every
// stage is full, and only then is in_ch.ready dropped.
// Reset empties the pipeline and loads the register defaults. The tile store
// is not cleared; its cells read as undefined until written.
module tile_map_overlay_compositor #(
  parameter int MAP_COLS = tmoc_pkg::TMOC_MAP_COLS,
  parameter int MAP_ROWS = tmoc_pkg::TMOC_MAP_ROWS
) (
  input  logic        clk,
  input  logic        rst_n,
  tmoc_in_if.sink     in_ch,
  tmoc_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [12:0] cfg_wdata
);
  import tmoc_pkg::*;

  logic [1:0]  mode_r;
  logic [7:0]  size_r;
  logic [8:0]  opa_r;
  logic [4:0]  pcol_r, prow_r;
  logic [1:0]  facing_r;
  logic [12:0] fwidth_r;
  logic [7:0]  size_c;
  logic [8:0]  opa_c;
  tmoc_cfg_t   cfg;

  logic       geo_valid, geo_ready, cell_valid, cell_ready;
  tmoc_geo_t  geo_data;
  tmoc_cell_t cell_data;

  // Setting registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_OFF;
      size_r   <= 8'd64;
      opa_r    <= OPA_FULL;
      pcol_r   <= '0;
      prow_r   <= '0;
      facing_r <= FACE_N;
      fwidth_r <= 13'd640;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_MODE:   mode_r   <= cfg_wdata[1:0];
        CFG_SIZE:   size_r   <= cfg_wdata[7:0];
        CFG_OPA:    opa_r    <= cfg_wdata[8:0];
        CFG_PCOL:   pcol_r   <= cfg_wdata[4:0];
        CFG_PROW:   prow_r   <= cfg_wdata[4:0];
        CFG_FACING: facing_r <= cfg_wdata[1:0];
        CFG_FWIDTH: fwidth_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clamped settings.
  always_comb begin
    if (size_r < SIZE_MIN)      size_c = SIZE_MIN;
    else if (size_r > SIZE_MAX) size_c = SIZE_MAX;
    else                        size_c = size_r;
    if (opa_r < OPA_MIN)        opa_c = OPA_MIN;
    else if (opa_r > OPA_MAX)   opa_c = OPA_MAX;
    else                        opa_c = opa_r;
    cfg = '{mode: mode_r, size: size_c, half: size_c[7:1], quarter: size_c[7:2],
            opa: opa_c, pcol: pcol_r, prow: prow_r, facing: facing_r, fwidth: fwidth_r};
  end

  tmoc_geom u_geom (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (in_ch.valid),
    .up_ready (in_ch.ready),
    .op       (in_ch.operation),
    .pos_x    (in_ch.pos_x),
    .pos_y    (in_ch.pos_y),
    .kind     (in_ch.cell_kind),
    .seen     (in_ch.cell_seen),
    .bg       (in_ch.background),
    .dn_valid (geo_valid),
    .dn_ready (geo_ready),
    .dn_data  (geo_data)
  );

  tmoc_cell #(
    .MAP_COLS (MAP_COLS),
    .MAP_ROWS (MAP_ROWS)
  ) u_cell (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (geo_valid),
    .up_ready (geo_ready),
    .up_data  (geo_data),
    .dn_valid (cell_valid),
    .dn_ready (cell_ready),
    .dn_data  (cell_data)
  );

  tmoc_blend u_blend (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (cell_valid),
    .up_ready (cell_ready),
    .up_data  (cell_data),
    .dn_valid (out_ch.valid),
    .dn_ready (out_ch.ready),
    .dn_pixel (out_ch.pixel_out)
  );

  // Nothing comes out of a pipeline that has just been reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("result presented right after reset");

  // Back pressure reaches a section only when the section after it is full.
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (geo_valid && !geo_ready))
    else $error("request refused while later stages have room");

  a_geo_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !geo_ready |-> (cell_valid && !cell_ready))
    else $error("geometry stalled while lookup has room");

  a_cell_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !cell_ready |-> (out_ch.valid && !out_ch.ready))
    else $error("lookup stalled while the output is free");

endmodule
